// File: rtl/tkst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Top-K score table package
// Shared types and constants for the ranked score table block.
// ----------------------------------------------------------------------------
package tkst_pkg;

  localparam int unsigned NUM_TABLES_MAX = 7;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 7;

  localparam logic [CFG_IDX_W-1:0] REG_TABLES_IN_USE = 3'd0;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_CHECK  = 2'd1,
    ACT_READ   = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_INS,
    S_WAIT,
    S_CLR
  } state_e;

  typedef struct packed {
    action_e            action;
    logic [2:0]         table_req;
    logic signed [31:0] score;
    logic [31:0]        entry_tag;
    logic [6:0]         slot;
  } req_t;

  typedef struct packed {
    logic [6:0]         inserted_at;
    logic               qualifies;
    logic signed [31:0] read_score;
    logic [31:0]        read_tag;
  } res_t;

  typedef struct packed {
    logic signed [31:0] score;
    logic [31:0]        tag;
  } entry_t;

  typedef struct packed {
    logic [2:0]                          tables_in_use;
    logic [NUM_TABLES_MAX-1:0][6:0]      slots;
  } cfg_t;

endpackage
`default_nettype wire

// File: rtl/tkst_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the number of tables in use and the slot count of each table.
// ----------------------------------------------------------------------------
module tkst_cfg
  import tkst_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                       cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic [CFG_IDX_W-1:0] slot_idx;

  assign cfg_ready_o = 1'b1;
  assign slot_idx    = cfg_index_i - 3'd1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_TABLES_IN_USE: cfg_d.tables_in_use = cfg_data_i[2:0];
        default:           cfg_d.slots[slot_idx] = cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// File: rtl/tkst_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Entry memory
// Single write, single read port store of score and tag words, with the
// read data registered.
// ----------------------------------------------------------------------------
module tkst_mem
  import tkst_pkg::*;
#(
  parameter int unsigned DEPTH  = 448,
  parameter int unsigned ADDR_W = 9
) (
  input  wire logic              clk_i,
  input  wire logic              ren_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output entry_t                 rdata_o,
  input  wire logic              wen_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire entry_t            wdata_i
);

  entry_t mem [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (wen_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ren_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: rtl/tkst_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Table sequencer
// Decodes each word, walks the table through the entry memory and forms the
// result. An insert streams the slots once, writing the new entry at the
// first lower score and carrying each displaced entry one slot down.
// ----------------------------------------------------------------------------
module tkst_seq
  import tkst_pkg::*;
#(
  parameter int unsigned SLOTS  = 64,
  parameter int unsigned TABLES = 7,
  parameter int unsigned DEPTH  = 448,
  parameter int unsigned ADDR_W = 9
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire req_t              req_i,
  input  wire cfg_t              cfg_i,
  output logic                   done_o,
  output res_t                   res_o,
  output logic                   mem_ren_o,
  output logic [ADDR_W-1:0]      mem_raddr_o,
  input  wire entry_t            mem_rdata_i,
  output logic                   mem_wen_o,
  output logic [ADDR_W-1:0]      mem_waddr_o,
  output entry_t                 mem_wdata_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  state_e               state_q, state_d;
  action_e              op_q, op_d;
  logic signed [31:0]   score_q, score_d;
  logic [31:0]          tag_q, tag_d;
  logic [ADDR_W-1:0]    base_q, base_d;
  logic [CNT_W-1:0]     n_q, n_d;
  logic [CNT_W-1:0]     idx_q, idx_d;
  logic [CNT_W-1:0]     pos_q, pos_d;
  logic                 vld_q, vld_d;
  logic                 hit_q, hit_d;
  logic [6:0]           ins_q, ins_d;
  entry_t               carry_q, carry_d;
  res_t                 res_q, res_d;
  logic                 done_q, done_d;

  logic                 accept;
  logic [2:0]           tm1;
  logic                 t_ok;
  logic [6:0]           sl_req;
  logic [CNT_W-1:0]     n_req;
  logic [ADDR_W-1:0]    base_req;
  logic                 go_ins, go_wait, go_clr;
  logic                 chk_ok, rd_ok;
  logic                 init_last, clr_last, ins_last;
  logic                 beat;
  logic [CNT_W-1:0]     pos_inc;

  assign accept   = start && !busy;
  assign tm1      = req_i.table_req - 3'd1;
  assign t_ok     = (req_i.table_req != 3'd0) && (32'(req_i.table_req) <= 32'(TABLES));
  assign sl_req   = t_ok ? cfg_i.slots[tm1] : 7'd0;
  assign n_req    = (32'(sl_req) > 32'(SLOTS)) ? CNT_W'(SLOTS) : CNT_W'(sl_req);
  assign base_req = ADDR_W'(tm1) * ADDR_W'(SLOTS);

  assign chk_ok   = t_ok && (n_req != '0) && (req_i.table_req <= cfg_i.tables_in_use);
  assign rd_ok    = t_ok && (req_i.slot != 7'd0) && (32'(req_i.slot) <= 32'(n_req));
  assign go_ins   = accept && (req_i.action == ACT_INSERT) && t_ok && (n_req != '0);
  assign go_wait  = accept && (((req_i.action == ACT_CHECK) && chk_ok) ||
                               ((req_i.action == ACT_READ) && rd_ok));
  assign go_clr   = accept && (req_i.action == ACT_CLEAR) && t_ok;

  assign init_last = idx_q == CNT_W'(DEPTH - 1);
  assign clr_last  = idx_q == CNT_W'(SLOTS - 1);
  assign ins_last  = vld_q && (pos_q == n_q - CNT_W'(1));
  assign beat      = $signed(score_q) > $signed(mem_rdata_i.score);
  assign pos_inc   = pos_q + CNT_W'(1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT: begin
        if (init_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (go_ins) begin
          state_d = S_INS;
        end else if (go_wait) begin
          state_d = S_WAIT;
        end else if (go_clr) begin
          state_d = S_CLR;
        end
      end
      S_INS: begin
        if (ins_last) state_d = S_IDLE;
      end
      S_WAIT: state_d = S_IDLE;
      S_CLR: begin
        if (clr_last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    op_d        = op_q;
    score_d     = score_q;
    tag_d       = tag_q;
    base_d      = base_q;
    n_d         = n_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    vld_d       = 1'b0;
    hit_d       = hit_q;
    ins_d       = ins_q;
    carry_d     = carry_q;
    res_d       = res_q;
    done_d      = 1'b0;
    mem_ren_o   = 1'b0;
    mem_raddr_o = '0;
    mem_wen_o   = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    case (state_q)
      S_INIT: begin
        mem_wen_o   = 1'b1;
        mem_waddr_o = ADDR_W'(idx_q);
        idx_d       = init_last ? '0 : idx_q + CNT_W'(1);
      end
      S_IDLE: begin
        if (accept) begin
          op_d    = req_i.action;
          score_d = req_i.score;
          tag_d   = req_i.entry_tag;
          base_d  = base_req;
          n_d     = n_req;
          idx_d   = '0;
          hit_d   = 1'b0;
          ins_d   = 7'd0;
          if (go_wait) begin
            mem_ren_o = 1'b1;
            if (req_i.action == ACT_CHECK) begin
              mem_raddr_o = base_req + ADDR_W'(n_req - CNT_W'(1));
            end else begin
              mem_raddr_o = base_req + ADDR_W'(req_i.slot - 7'd1);
            end
          end else if (!go_ins && !go_clr) begin
            done_d = 1'b1;
            res_d  = '0;
          end
        end
      end
      S_WAIT: begin
        done_d = 1'b1;
        res_d  = '0;
        if (op_q == ACT_CHECK) begin
          res_d.qualifies = beat;
        end else begin
          res_d.read_score = mem_rdata_i.score;
          res_d.read_tag   = mem_rdata_i.tag;
        end
      end
      S_CLR: begin
        mem_wen_o   = 1'b1;
        mem_waddr_o = base_q + ADDR_W'(idx_q);
        idx_d       = idx_q + CNT_W'(1);
        if (clr_last) begin
          done_d = 1'b1;
          res_d  = '0;
        end
      end
      S_INS: begin
        if (idx_q < n_q) begin
          mem_ren_o   = 1'b1;
          mem_raddr_o = base_q + ADDR_W'(idx_q);
          idx_d       = idx_q + CNT_W'(1);
          vld_d       = 1'b1;
          pos_d       = idx_q;
        end
        if (vld_q) begin
          if (hit_q) begin
            mem_wen_o   = 1'b1;
            mem_waddr_o = base_q + ADDR_W'(pos_q);
            mem_wdata_o = carry_q;
            carry_d     = mem_rdata_i;
          end else if (beat) begin
            mem_wen_o         = 1'b1;
            mem_waddr_o       = base_q + ADDR_W'(pos_q);
            mem_wdata_o.score = score_q;
            mem_wdata_o.tag   = tag_q;
            hit_d             = 1'b1;
            ins_d             = 7'(pos_inc);
            carry_d           = mem_rdata_i;
          end
        end
        if (ins_last) begin
          done_d = 1'b1;
          res_d  = '0;
          if (hit_q) begin
            res_d.inserted_at = ins_q;
          end else if (beat) begin
            res_d.inserted_at = 7'(pos_inc);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      idx_q   <= '0;
      vld_q   <= 1'b0;
      hit_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      vld_q   <= vld_d;
      hit_q   <= hit_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    score_q <= score_d;
    tag_q   <= tag_d;
    base_q  <= base_d;
    n_q     <= n_d;
    pos_q   <= pos_d;
    ins_q   <= ins_d;
    carry_q <= carry_d;
    res_q   <= res_d;
  end

  assign busy   = state_q != S_IDLE;
  assign done_o = done_q;
  assign res_o  = res_q;

  a_done_not_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == S_IDLE))
    else $error("result shown while the sequencer is still busy");

  a_no_rw_clash : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_wen_o && mem_ren_o) |-> (mem_waddr_o != mem_raddr_o))
    else $error("read and write of the same entry in one cycle");

  a_no_done_in_init : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INIT) |-> !done_q)
    else $error("result produced during the clearing sweep");

  a_ins_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && ($past(state_q) == S_INS)) |-> (32'(res_q.inserted_at) <= 32'(n_q)))
    else $error("inserted slot beyond the table's slot count");

endmodule
`default_nettype wire

// File: rtl/top_k_score_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Top-K score table
// Keeps several descending ranked tables of score and tag pairs in one
// entry memory; supports insert, check, read and clear of a table.
// ----------------------------------------------------------------------------
// An insert reads each of the table's slots once through the single read
// port; check and read take one memory read, clear writes all SLOTS entries
// of the table, and rejected words give a zero result with no memory access.
// A new word is accepted in the cycle its predecessor's result is shown;
// the receiver cannot stall. After reset the block sweeps the whole memory
// to zero with busy high.
module top_k_score_table
  import tkst_pkg::*;
#(
  parameter int unsigned SLOTS  = 64,
  parameter int unsigned TABLES = 7
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire req_t                  req_i,
  output logic                       done_o,
  output res_t                       res_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned DEPTH  = TABLES * SLOTS;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cfg_t              cfg;
  logic              mem_ren;
  logic [ADDR_W-1:0] mem_raddr;
  entry_t            mem_rdata;
  logic              mem_wen;
  logic [ADDR_W-1:0] mem_waddr;
  entry_t            mem_wdata;

  tkst_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  tkst_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk_i   (clk_i),
    .ren_i   (mem_ren),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata),
    .wen_i   (mem_wen),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata)
  );

  tkst_seq #(
    .SLOTS  (SLOTS),
    .TABLES (TABLES),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .cfg_i       (cfg),
    .done_o      (done_o),
    .res_o       (res_o),
    .mem_ren_o   (mem_ren),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .mem_wen_o   (mem_wen),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata)
  );

endmodule
`default_nettype wire

// File: test/top_k_score_table_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Top-K score table testbench
// Drives insert, check, read and clear words into the ranked score tables
// under several register settings, predicts every result from its own copy
// of the tables and compares each result word field by field, in order.
// ----------------------------------------------------------------------------
module top_k_score_table_test;
  import tkst_pkg::*;

  localparam int SLOT_COUNT  = 64;
  localparam int TABLE_COUNT = 7;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 80;
  localparam int PRINT_LIMIT = 40;
  localparam logic [CFG_IDX_W-1:0] REG_SLOTS_FIRST = 3'd1;

  class score_table_board;
    logic signed [31:0] score_mem [TABLE_COUNT][SLOT_COUNT];
    logic [31:0]        tag_mem [TABLE_COUNT][SLOT_COUNT];
    logic [2:0]         tables_used;
    logic [6:0]         slot_regs [TABLE_COUNT];
    res_t               expected_q [$];
    int unsigned        mismatches;

    function new();
      for (int t = 0; t < TABLE_COUNT; t++) begin
        slot_regs[t] = '0;
        for (int h = 0; h < SLOT_COUNT; h++) begin
          score_mem[t][h] = '0;
          tag_mem[t][h]   = '0;
        end
      end
      tables_used = '0;
      mismatches  = 0;
    endfunction

    function void write_register(logic [2:0] idx, logic [6:0] data);
      if (idx == REG_TABLES_IN_USE) begin
        tables_used = data[2:0];
      end else begin
        slot_regs[idx - 1] = data;
      end
    endfunction

    function int ranked_slots(int t);
      if (t < 1 || t > TABLE_COUNT) return 0;
      return (int'(slot_regs[t-1]) > SLOT_COUNT) ? SLOT_COUNT : int'(slot_regs[t-1]);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_request(req_t r);
      res_t e;
      int   t;
      int   n;
      e = '0;
      t = int'(r.table_req);
      if (t >= 1 && t <= TABLE_COUNT) begin
        n = ranked_slots(t);
        case (r.action)
          ACT_INSERT: begin
            for (int h = 0; h < n; h++) begin
              if (r.score > score_mem[t-1][h]) begin
                for (int i = n - 1; i > h; i--) begin
                  score_mem[t-1][i] = score_mem[t-1][i-1];
                  tag_mem[t-1][i]   = tag_mem[t-1][i-1];
                end
                score_mem[t-1][h] = r.score;
                tag_mem[t-1][h]   = r.entry_tag;
                e.inserted_at     = 7'(h + 1);
                break;
              end
            end
          end
          ACT_CHECK: begin
            if (n > 0 && t <= int'(tables_used) && r.score > score_mem[t-1][n-1]) begin
              e.qualifies = 1'b1;
            end
          end
          ACT_READ: begin
            if (r.slot >= 7'd1 && int'(r.slot) <= n) begin
              e.read_score = score_mem[t-1][r.slot-1];
              e.read_tag   = tag_mem[t-1][r.slot-1];
            end
          end
          default: begin
            for (int h = 0; h < SLOT_COUNT; h++) begin
              score_mem[t-1][h] = '0;
              tag_mem[t-1][h]   = '0;
            end
          end
        endcase
      end
      expected_q.push_back(e);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) begin
        $display("%0t mismatch: %s", $realtime, what);
      end
    endtask

    task check_result(res_t got);
      res_t e;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result word %h with none expected", got));
      end else begin
        e = expected_q.pop_front();
        if (got.inserted_at !== e.inserted_at) begin
          report_mismatch($sformatf("inserted_at %0d, expected %0d",
                                    got.inserted_at, e.inserted_at));
        end
        if (got.qualifies !== e.qualifies) begin
          report_mismatch($sformatf("qualifies %b, expected %b", got.qualifies, e.qualifies));
        end
        if (got.read_score !== e.read_score) begin
          report_mismatch($sformatf("read_score %0d, expected %0d",
                                    got.read_score, e.read_score));
        end
        if (got.read_tag !== e.read_tag) begin
          report_mismatch($sformatf("read_tag %h, expected %h", got.read_tag, e.read_tag));
        end
      end
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  req_t                  req_i = '0;
  logic                  done_o;
  res_t                  res_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  score_table_board board = new();
  bit               idle_on = 1'b1;
  int               quiet_cycles = 0;

  top_k_score_table uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      board.check_result(res_o);
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input req_t w);
    while (idle_on && $urandom_range(0, 99) < 35) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    board.note_request(w);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [6:0] data);
    while (idle_on && $urandom_range(0, 99) < 35) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.write_register(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  task automatic program_tables(input logic [6:0] in_use, input logic [0:6][6:0] counts);
    wait_drained();
    @(posedge clk_i);
    write_reg(REG_TABLES_IN_USE, in_use);
    for (int k = 0; k < TABLE_COUNT; k++) begin
      write_reg(REG_SLOTS_FIRST + 3'(k), counts[k]);
    end
  endtask

  function automatic req_t make_word(action_e act, logic [2:0] tbl, logic [31:0] sc,
                                     logic [31:0] tag, logic [6:0] sl);
    req_t w;
    w.action    = act;
    w.table_req = tbl;
    w.score     = sc;
    w.entry_tag = tag;
    w.slot      = sl;
    return w;
  endfunction

  function automatic req_t random_word();
    req_t        w;
    int unsigned pick;
    int          n;
    w.table_req = ($urandom_range(0, 19) == 0) ? 3'd0 : 3'($urandom_range(1, 7));
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      w.action = ACT_INSERT;
    end else if (pick < 70) begin
      w.action = ACT_CHECK;
    end else if (pick < 96) begin
      w.action = ACT_READ;
    end else begin
      w.action = ACT_CLEAR;
    end
    case ($urandom_range(0, 9))
      0: w.score = $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0: w.score = 32'h7fff_ffff;
          1: w.score = 32'h8000_0000;
          2: w.score = 32'hffff_ffff;
          default: w.score = 32'h0000_0000;
        endcase
      end
      default: w.score = 32'($urandom_range(0, 60)) - 32'd20;
    endcase
    w.entry_tag = $urandom;
    n = board.ranked_slots(int'(w.table_req));
    w.slot = ($urandom_range(0, 4) == 0) ? 7'($urandom) : 7'($urandom_range(0, n + 1));
    return w;
  endfunction

  task automatic run_phase(input int words);
    for (int i = 0; i < words; i++) begin
      if (i == words / 2) begin
        wait_drained();
      end
      send_word(random_word());
    end
  endtask

  initial begin
    logic [0:6][6:0] counts;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Registers still at their reset values: no slots, no table in use.
    send_word(make_word(ACT_INSERT, 3'd1, 32'd100, 32'h0000_0001, 7'd1));
    send_word(make_word(ACT_CHECK, 3'd1, 32'd5, 32'h0, 7'd0));

    program_tables(7'd5, {7'd1, 7'd2, 7'd3, 7'd64, 7'd127, 7'd0, 7'd8});
    send_word(make_word(ACT_INSERT, 3'd2, 32'd100, 32'h0000_00aa, 7'd0));
    send_word(make_word(ACT_INSERT, 3'd2, 32'd100, 32'h0000_00bb, 7'd0));
    send_word(make_word(ACT_INSERT, 3'd2, 32'd200, 32'h0000_00cc, 7'd0));
    send_word(make_word(ACT_INSERT, 3'd2, -32'sd5, 32'h0000_00dd, 7'd0));
    send_word(make_word(ACT_INSERT, 3'd1, 32'h7fff_ffff, 32'hffff_ffff, 7'd127));
    send_word(make_word(ACT_INSERT, 3'd1, 32'h8000_0000, 32'h0, 7'd0));
    send_word(make_word(ACT_INSERT, 3'd4, 32'hffff_ffff, 32'h1234_5678, 7'd0));
    send_word(make_word(ACT_INSERT, 3'd4, 32'd1, 32'h8765_4321, 7'd0));
    send_word(make_word(ACT_INSERT, 3'd0, 32'd50, 32'h5555_5555, 7'd1));
    send_word(make_word(ACT_CHECK, 3'd0, 32'd50, 32'h0, 7'd1));
    send_word(make_word(ACT_READ, 3'd0, 32'd0, 32'h0, 7'd1));
    send_word(make_word(ACT_CLEAR, 3'd0, 32'd0, 32'h0, 7'd0));
    send_word(make_word(ACT_CHECK, 3'd2, 32'd100, 32'h0, 7'd0));
    send_word(make_word(ACT_CHECK, 3'd2, 32'd101, 32'h0, 7'd0));
    send_word(make_word(ACT_CHECK, 3'd6, 32'h7fff_ffff, 32'h0, 7'd0));
    send_word(make_word(ACT_CHECK, 3'd7, 32'd5, 32'h0, 7'd0));
    send_word(make_word(ACT_CHECK, 3'd4, 32'd1, 32'h0, 7'd0));
    send_word(make_word(ACT_READ, 3'd2, 32'd0, 32'h0, 7'd0));
    send_word(make_word(ACT_READ, 3'd2, 32'd0, 32'h0, 7'd1));
    send_word(make_word(ACT_READ, 3'd2, 32'd0, 32'h0, 7'd3));
    send_word(make_word(ACT_READ, 3'd5, 32'd0, 32'h0, 7'd127));
    send_word(make_word(ACT_READ, 3'd4, 32'd0, 32'h0, 7'd64));
    send_word(make_word(ACT_READ, 3'd1, 32'd0, 32'h0, 7'd1));
    send_word(make_word(ACT_CLEAR, 3'd2, 32'd0, 32'h0, 7'd0));
    send_word(make_word(ACT_READ, 3'd2, 32'd0, 32'h0, 7'd1));
    send_word(make_word(ACT_INSERT, 3'd7, 32'h8000_0001, 32'h0f0f_0f0f, 7'd0));
    send_word(make_word(ACT_INSERT, 3'd6, 32'd9, 32'hf0f0_f0f0, 7'd0));

    program_tables(7'd7, {7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd6, 7'd8});
    run_phase(260);
    program_tables(7'd3, {7'd64, 7'd0, 7'd127, 7'd2, 7'd7, 7'd1, 7'd16});
    run_phase(260);
    program_tables(7'd0, {7'd5, 7'd5, 7'd5, 7'd5, 7'd5, 7'd5, 7'd5});
    run_phase(200);
    program_tables(7'd7, {7'd64, 7'd64, 7'd64, 7'd64, 7'd64, 7'd64, 7'd64});
    run_phase(150);

    // A long stretch with the sender never pausing; only the low bits of the
    // in-use register count.
    idle_on = 1'b0;
    program_tables(7'h7d, {7'd3, 7'd1, 7'd0, 7'd4, 7'd127, 7'd65, 7'd2});
    run_phase(260);
    idle_on = 1'b1;

    for (int k = 0; k < TABLE_COUNT; k++) counts[k] = 7'($urandom_range(1, 10));
    program_tables(7'd6, counts);
    run_phase(260);
    for (int k = 0; k < TABLE_COUNT; k++) counts[k] = 7'($urandom_range(0, 127));
    program_tables(7'($urandom_range(0, 7)), counts);
    run_phase(330);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
